// ===== hw/rtl/note_voice_allocator_timer_core_assert.svh =====
// assertion macros for the note voice allocator timer core
// no dependencies; included by the modules that carry assertions
`ifndef NOTE_VOICE_ALLOCATOR_TIMER_CORE_ASSERT_SVH
`define NOTE_VOICE_ALLOCATOR_TIMER_CORE_ASSERT_SVH

// same-cycle implication, masked while reset is held
`define NVAT_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("nvat assertion failed");

// next-cycle implication, masked while reset is held
`define NVAT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("nvat assertion failed");

`endif

// ===== hw/rtl/nvat_pkg.sv =====
// shared types and constants for the note voice allocator timer core
// no dependencies
package nvat_pkg;

    // field widths
    localparam int STATUS_W = 8;
    localparam int DATA_W   = 8;
    localparam int LEN_W    = 16;
    localparam int CHAN_W   = 4;

    // default voice count and per-request note-off limit
    localparam int VOICE_COUNT_DEF = 16;
    localparam int RESULT_LIMIT    = 16;
    localparam int CNT_W           = $clog2(RESULT_LIMIT + 1);

    // request kinds carried on tuser
    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // midi codes
    localparam logic [CHAN_W-1:0]   NOTE_ON_NIBBLE = 4'h9;
    localparam logic [STATUS_W-1:0] CHAN_MASK      = 8'h0F;
    localparam logic [STATUS_W-1:0] NOTE_OFF       = 8'h80;

    // write request into the voice store
    typedef struct packed {
        logic                en;    // write the remaining count
        logic                full;  // also write note and channel
        logic [LEN_W-1:0]    rem;
        logic [DATA_W-1:0]   note;
        logic [CHAN_W-1:0]   chan;
    } mem_wr_t;

endpackage

// ===== hw/rtl/nvat_voice_mem.sv =====
// per-voice store: remaining count, note and channel, one read and one write port
// depends on nvat_pkg
module nvat_voice_mem #(
    parameter int VOICE_COUNT = nvat_pkg::VOICE_COUNT_DEF,
    parameter int IDX_W       = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [IDX_W-1:0]              rd_addr,
    input  logic [IDX_W-1:0]              wr_addr,
    input  nvat_pkg::mem_wr_t             wr_req,
    output logic [nvat_pkg::LEN_W-1:0]    rd_rem,
    output logic [nvat_pkg::DATA_W-1:0]   rd_note,
    output logic [nvat_pkg::CHAN_W-1:0]   rd_chan
);
    import nvat_pkg::*;

    logic [LEN_W-1:0]  rem_mem  [VOICE_COUNT];
    logic [DATA_W-1:0] note_mem [VOICE_COUNT];
    logic [CHAN_W-1:0] chan_mem [VOICE_COUNT];

    logic [VOICE_COUNT-1:0] valid_reg;
    logic [VOICE_COUNT-1:0] valid_next;
    logic [LEN_W-1:0]       rd_rem_reg;
    logic [DATA_W-1:0]      rd_note_reg;
    logic [CHAN_W-1:0]      rd_chan_reg;

    // a voice never written reads as free
    always_comb begin
        valid_next = valid_reg;
        if (wr_req.en) begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // write port
    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            rem_mem[wr_addr] <= wr_req.rem;
            if (wr_req.full) begin
                note_mem[wr_addr] <= wr_req.note;
                chan_mem[wr_addr] <= wr_req.chan;
            end
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_rem_reg  <= valid_reg[rd_addr] ? rem_mem[rd_addr] : '0;
            rd_note_reg <= note_mem[rd_addr];
            rd_chan_reg <= chan_mem[rd_addr];
        end
    end

    assign rd_rem  = rd_rem_reg;
    assign rd_note = rd_note_reg;
    assign rd_chan = rd_chan_reg;

endmodule

// ===== hw/rtl/note_voice_allocator_timer_core.sv =====
// Flow: a plain event goes through ST_EMIT into the output register; a note-on or a
// tick scans the voices one at a time, each voice through ST_RD and then ST_EX.
// A new request is taken only in idle, once the previous one is done; the pace is set by
// the single read/decrement/write pass over the voice store, plus output back-pressure.
// Reset: synchronous, active low; all voices free at once, no clearing pass.
module note_voice_allocator_timer_core #(
    parameter int VOICE_COUNT = nvat_pkg::VOICE_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] status_byte, [15:8] data_one, [23:16] data_two, [39:24] note_length
    input  logic [39:0] s_axis_tdata,
    // [0] op
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_status, [15:8] out_data_one, [23:16] out_data_two, [39:24] out_length
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import nvat_pkg::*;

    `include "note_voice_allocator_timer_core_assert.svh"

    localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(VOICE_COUNT - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_EX    = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                hold_valid_reg, hold_valid_next;
    logic [CHAN_W-1:0]   hold_chan_reg, hold_chan_next;
    logic [DATA_W-1:0]   hold_note_reg, hold_note_next;

    // latched request
    logic                op_reg;
    logic [STATUS_W-1:0] st_reg;
    logic [DATA_W-1:0]   d1_reg, d2_reg;
    logic [LEN_W-1:0]    len_reg;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic                m_last_reg, m_last_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [DATA_W-1:0]   m_d1_reg, m_d1_next;
    logic [DATA_W-1:0]   m_d2_reg, m_d2_next;
    logic [LEN_W-1:0]    m_len_reg, m_len_next;

    logic                s_accept;
    logic                out_free;
    logic                rd_en;
    mem_wr_t             wr_req;
    logic [LEN_W-1:0]    rd_rem;
    logic [DATA_W-1:0]   rd_note;
    logic [CHAN_W-1:0]   rd_chan;
    logic [LEN_W-1:0]    dec;
    logic                rem_zero;
    logic                expire;
    logic                is_note_on;

    nvat_voice_mem #(
        .VOICE_COUNT (VOICE_COUNT),
        .IDX_W       (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .wr_addr (idx_reg),
        .wr_req  (wr_req),
        .rd_rem  (rd_rem),
        .rd_note (rd_note),
        .rd_chan (rd_chan)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign is_note_on    = (s_axis_tdata[7:4] == NOTE_ON_NIBBLE);

    // shared decrement and zero test on the voice just read
    assign dec      = rd_rem - LEN_W'(1);
    assign rem_zero = (rd_rem == '0);
    assign expire   = !rem_zero && (dec == '0) && (cnt_reg < CNT_W'(RESULT_LIMIT));

    // sequencer
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_chan_next  = hold_chan_reg;
        hold_note_next  = hold_note_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_last_next     = m_last_reg;
        m_status_next   = m_status_reg;
        m_d1_next       = m_d1_reg;
        m_d2_next       = m_d2_reg;
        m_len_next      = m_len_reg;
        rd_en           = 1'b0;
        wr_req          = '0;
        case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                cnt_next = '0;
                if (s_accept) begin
                    if (s_axis_tuser == OP_TICK || is_note_on) begin
                        state_next = ST_RD;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_RD: begin
                rd_en      = 1'b1;
                state_next = ST_EX;
            end
            ST_EX: begin
                if (op_reg == OP_TICK) begin
                    // hold back while the pending note-off cannot move on
                    if (!(expire && hold_valid_reg && !out_free)) begin
                        wr_req.en  = !rem_zero;
                        wr_req.rem = dec;
                        if (expire) begin
                            if (hold_valid_reg) begin
                                m_valid_next  = 1'b1;
                                m_last_next   = 1'b0;
                                m_status_next = NOTE_OFF | {4'h0, hold_chan_reg};
                                m_d1_next     = hold_note_reg;
                                m_d2_next     = '0;
                                m_len_next    = '0;
                            end
                            hold_valid_next = 1'b1;
                            hold_chan_next  = rd_chan;
                            hold_note_next  = rd_note;
                            cnt_next        = cnt_reg + CNT_W'(1);
                        end
                        if (idx_reg == IDX_LAST) begin
                            state_next = ST_FLUSH;
                        end else begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = ST_RD;
                        end
                    end
                end else begin
                    // note-on: claim the first free voice
                    if (rem_zero) begin
                        wr_req.en   = 1'b1;
                        wr_req.full = 1'b1;
                        wr_req.rem  = len_reg;
                        wr_req.note = d1_reg;
                        wr_req.chan = CHAN_W'(st_reg & CHAN_MASK);
                        state_next  = ST_EMIT;
                    end else if (idx_reg == IDX_LAST) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            ST_FLUSH: begin
                if (!hold_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_last_next     = 1'b1;
                    m_status_next   = NOTE_OFF | {4'h0, hold_chan_reg};
                    m_d1_next       = hold_note_reg;
                    m_d2_next       = '0;
                    m_len_next      = '0;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_last_next   = 1'b1;
                    m_status_next = st_reg;
                    m_d1_next     = d1_reg;
                    m_d2_next     = d2_reg;
                    m_len_next    = len_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        hold_chan_reg <= hold_chan_next;
        hold_note_reg <= hold_note_next;
        m_last_reg    <= m_last_next;
        m_status_reg  <= m_status_next;
        m_d1_reg      <= m_d1_next;
        m_d2_reg      <= m_d2_next;
        m_len_reg     <= m_len_next;
        if (s_accept) begin
            op_reg  <= s_axis_tuser;
            st_reg  <= s_axis_tdata[7:0];
            d1_reg  <= s_axis_tdata[15:8];
            d2_reg  <= s_axis_tdata[23:16];
            len_reg <= s_axis_tdata[39:24];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {m_len_reg, m_d2_reg, m_d1_reg, m_status_reg};

    // pending note-off only lives during a tick scan
    `NVAT_ASSERT(a_hold_in_scan, aclk, aresetn, hold_valid_reg, (state_reg == ST_RD || state_reg == ST_EX || state_reg == ST_FLUSH))
    // note-off count never passes the limit
    `NVAT_ASSERT(a_cnt_limit, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(RESULT_LIMIT))
    // voice store is written only while a voice is being worked on
    `NVAT_ASSERT(a_wr_in_ex, aclk, aresetn, wr_req.en, state_reg == ST_EX)
    // an accepted request always leaves idle
    `NVAT_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_accept, state_reg != ST_IDLE)

endmodule

// ===== test/note_voice_allocator_timer_core_test.sv =====
// testbench for note_voice_allocator_timer_core: directed and random midi event and tick
// requests, each result checked against a voice allocator model kept inside the bench
// depends on nvat_pkg and note_voice_allocator_timer_core
module note_voice_allocator_timer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nvat_pkg::*;

    localparam int          VOICES      = VOICE_COUNT_DEF;
    localparam int          SCAN_CYCLES = 2 * VOICES + 2;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          REPORT_MAX  = 10;

    typedef enum int {RX_STEADY, RX_CHOPPY, RX_LONG_STALL} rx_style_t;

    // one result as seen on the master side
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   key;
        logic [DATA_W-1:0]   vel;
        logic [LEN_W-1:0]    len;
        logic                last;
    } midi_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [7:0] status_byte, [15:8] data_one, [23:16] data_two, [39:24] note_length
    logic [39:0] s_axis_tdata = '0;
    // [0] op
    logic        s_axis_tuser = OP_EVENT;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] out_status, [15:8] out_data_one, [23:16] out_data_two, [39:24] out_length
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    // expected results, oldest first
    midi_out_t expected_notes[$];

    // model copy of the voice store
    logic [LEN_W-1:0]  voice_left [VOICES];
    logic [DATA_W-1:0] voice_key  [VOICES];
    logic [CHAN_W-1:0] voice_chan [VOICES];

    int          fail_count = 0;
    int unsigned clk_count = 0;
    bit          tx_bursty = 1'b0;
    int          burst_left = 0;
    rx_style_t   rx_style = RX_STEADY;
    int          stall_left = 0;

    note_voice_allocator_timer_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        clk_count++;
        if (clk_count > CYCLE_LIMIT) begin
            $display("note_voice_allocator_timer_core test failed");
            $finish;
        end
    end

    function automatic void flag_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("ERROR at %0t: %s", $realtime, what);
    endfunction

    // forward an event, allocate a voice or run one tick, queueing the results it should give
    function automatic void predict_voices(input logic kind, input logic [STATUS_W-1:0] status,
                                           input logic [DATA_W-1:0] key,
                                           input logic [DATA_W-1:0] vel,
                                           input logic [LEN_W-1:0] len);
        int        free_idx;
        int        expiring;
        int        emitted;
        midi_out_t res;
        free_idx = -1;
        expiring = 0;
        emitted = 0;
        if (kind == OP_EVENT) begin
            // note-on claims the lowest free voice, or is dropped
            if (status[7:4] == NOTE_ON_NIBBLE) begin
                for (int v = 0; v < VOICES; v++)
                    if (free_idx < 0 && voice_left[v] == '0)
                        free_idx = v;
                if (free_idx < 0)
                    return;
                voice_key[free_idx]  = key;
                voice_chan[free_idx] = status[CHAN_W-1:0];
                voice_left[free_idx] = len;
            end
            res = '{status, key, vel, len, 1'b1};
            expected_notes.push_back(res);
        end else begin
            // tick: count voices about to expire so the final note-off gets last
            for (int v = 0; v < VOICES; v++)
                if (voice_left[v] == LEN_W'(1))
                    expiring++;
            if (expiring > RESULT_LIMIT)
                expiring = RESULT_LIMIT;
            for (int v = 0; v < VOICES; v++) begin
                if (voice_left[v] != '0) begin
                    voice_left[v] = voice_left[v] - 1'b1;
                    if (voice_left[v] == '0 && emitted < RESULT_LIMIT) begin
                        res = '{NOTE_OFF | (STATUS_W'(voice_chan[v]) & CHAN_MASK),
                                voice_key[v], '0, '0, emitted == expiring - 1};
                        expected_notes.push_back(res);
                        emitted++;
                    end
                end
            end
        end
    endfunction

    // present one request, wait for the handshake, then maybe leave a gap
    task automatic send_item(input logic kind, input logic [STATUS_W-1:0] status,
                             input logic [DATA_W-1:0] key, input logic [DATA_W-1:0] vel,
                             input logic [LEN_W-1:0] len);
        int gap;
        @(negedge aclk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = {len, vel, key, status};
        do @(posedge aclk); while (!s_axis_tready);
        predict_voices(kind, status, key, vel, len);
        if (tx_bursty) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap = $urandom_range(1, 8);
                @(negedge aclk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
                burst_left = $urandom_range(0, 7);
            end
        end
    endtask

    // stop sending and wait for every expected result, then for the scan to settle
    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (expected_notes.size() != 0)
            @(posedge aclk);
        repeat (SCAN_CYCLES + 4) @(posedge aclk);
    endtask

    // receiver back-pressure
    always @(negedge aclk) begin
        case (rx_style)
            RX_STEADY: begin
                m_axis_tready = 1'b1;
            end
            RX_CHOPPY: begin
                m_axis_tready = ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_axis_tready = 1'b0;
                end else if ($urandom_range(0, 11) == 0) begin
                    stall_left = $urandom_range(1, 20);
                    m_axis_tready = 1'b0;
                end else begin
                    m_axis_tready = 1'b1;
                end
            end
        endcase
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        midi_out_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_notes.size() == 0) begin
                flag_failure($sformatf("unexpected result status=%h d1=%h d2=%h len=%h last=%b",
                                       m_axis_tdata[7:0], m_axis_tdata[15:8],
                                       m_axis_tdata[23:16], m_axis_tdata[39:24],
                                       m_axis_tlast));
            end else begin
                want = expected_notes.pop_front();
                if (m_axis_tdata[7:0] !== want.status || m_axis_tdata[15:8] !== want.key ||
                    m_axis_tdata[23:16] !== want.vel || m_axis_tdata[39:24] !== want.len ||
                    m_axis_tlast !== want.last)
                    flag_failure($sformatf(
                        "expected %h/%h/%h/%h last %b, got %h/%h/%h/%h last %b",
                        want.status, want.key, want.vel, want.len, want.last,
                        m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                        m_axis_tdata[39:24], m_axis_tlast));
            end
        end
    end

    // plain events forwarded, idle tick, zero-length note-on, one short note
    task automatic test_forwarding();
        send_item(OP_EVENT, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_item(OP_EVENT, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        send_item(OP_EVENT, 8'h8A, 8'h3C, 8'h40, 16'h1234);
        send_item(OP_EVENT, 8'hB5, 8'hAA, 8'h55, 16'hA5A5);
        send_item(OP_TICK, STATUS_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
                  LEN_W'($urandom));
        send_item(OP_EVENT, 8'h9F, 8'h7F, 8'h7F, 16'h0000);
        send_item(OP_EVENT, 8'h93, 8'h45, 8'h01, 16'h0002);
        send_item(OP_TICK, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_item(OP_TICK, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    endtask

    // every voice busy, an extra note-on dropped, then all expire on one tick
    task automatic test_full_voices();
        for (int v = 0; v < VOICES; v++)
            send_item(OP_EVENT, {NOTE_ON_NIBBLE, 4'(v)}, 8'(8'h20 + 7 * v), 8'(v), 16'h0001);
        send_item(OP_EVENT, 8'h9C, 8'h11, 8'h22, 16'h0003);
        send_item(OP_TICK, 8'h00, 8'h00, 8'h00, 16'h0000);
    endtask

    // weighted mix of note-ons, ticks and other events
    task automatic test_random_traffic(input int count, input int on_pct, input int tick_pct,
                                       input int max_len);
        int                  pick;
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    len;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < on_pct) begin
                status = {NOTE_ON_NIBBLE, 4'($urandom)};
                len = ($urandom_range(0, 9) == 0) ? '0 : LEN_W'($urandom_range(1, max_len));
                send_item(OP_EVENT, status, DATA_W'($urandom), DATA_W'($urandom), len);
            end else if (pick < on_pct + tick_pct) begin
                send_item(OP_TICK, STATUS_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
                          LEN_W'($urandom));
            end else begin
                do status = STATUS_W'($urandom); while (status[7:4] == NOTE_ON_NIBBLE);
                send_item(OP_EVENT, status, DATA_W'($urandom), DATA_W'($urandom),
                          LEN_W'($urandom));
            end
        end
    endtask

    initial begin
        for (int v = 0; v < VOICES; v++) begin
            voice_left[v] = '0;
            voice_key[v]  = '0;
            voice_chan[v] = '0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_forwarding();
        rx_style = RX_CHOPPY;
        test_full_voices();
        wait_drained();

        // balanced traffic, bursty sender, steady then stalling receiver
        tx_bursty = 1'b1;
        rx_style  = RX_STEADY;
        test_random_traffic(35, 45, 35, 8);
        rx_style  = RX_LONG_STALL;
        test_random_traffic(35, 45, 35, 8);
        wait_drained();

        // note-on heavy so voices fill and requests get dropped
        tx_bursty = 1'b0;
        rx_style  = RX_CHOPPY;
        test_random_traffic(57, 70, 15, 12);

        // tick heavy so many voices expire together
        tx_bursty = 1'b1;
        rx_style  = RX_LONG_STALL;
        test_random_traffic(57, 25, 60, 6);

        wait_drained();
        if (fail_count == 0)
            $display("note_voice_allocator_timer_core test passed");
        else
            $display("note_voice_allocator_timer_core test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/nvat_pkg.sv
hw/rtl/nvat_voice_mem.sv
hw/rtl/note_voice_allocator_timer_core.sv
test/note_voice_allocator_timer_core_test.sv
